FILE: sv/lla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_pkg: shared types and constants for the decaying life-like automaton
// Grid geometry, level encoding, item formats, operation and register codes.
// ----------------------------------------------------------------------------
package lla_pkg;

    // Grid geometry and level range
    localparam int GRID_ROWS   = 128;
    localparam int GRID_COLS   = 128;
    localparam int ALIVE_LEVEL = 5;

    localparam int CELLS   = GRID_ROWS * GRID_COLS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int ROW_W   = $clog2(GRID_ROWS);
    localparam int COL_W   = $clog2(GRID_COLS + 1);   // sweep runs one column past the edge
    localparam int LVL_W   = $clog2(ALIVE_LEVEL + 1);

    localparam int MASK_W    = 9;                     // neighbor counts 0..8
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 1;

    typedef logic [LVL_W-1:0] t_level;

    localparam t_level LVL_ALIVE = LVL_W'(ALIVE_LEVEL);
    localparam t_level LVL_DECAY = LVL_W'(ALIVE_LEVEL - 1);

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_STEP  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BORN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] row;
        logic [6:0] col;
        logic [2:0] level_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0] level_out;
        logic [1:0] op_done;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_STEP,
        S_FINISH
    } t_state;

endpackage

FILE: sv/lla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lla_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/life_like_automaton_with_decay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_with_decay: generations cellular automaton with decay
// Cell grid in two RAM banks; write, read and generation-step items.
// ----------------------------------------------------------------------------
// The block holds a GRID_ROWS x GRID_COLS grid of levels 0..ALIVE_LEVEL in two
// RAM banks (front and back) and takes one item at a time; o_in_stall is high
// whenever an item is in progress. After reset a clearing pass zeroes the front
// bank, one cell per cycle, before the first item is taken; configuration
// writes are taken meanwhile. A write goes from idle to the finish state, and a
// read passes through a read-wait state that captures the RAM data before it
// reaches finish. A step sweeps the grid row by row and column by column; the
// single read port of the front bank fetches the three cells above, at and
// below the current row in turn for each column, and the sweep runs one column
// past the edge to flush the 3x3 window. New levels go to the back bank, and
// the banks swap when the sweep ends. Every item but an unused mode returns one
// result; a result waits in the output register while the output is stalled,
// and the next item is taken once it has been loaded.
// ----------------------------------------------------------------------------
module life_like_automaton_with_decay (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  lla_pkg::t_in_item                   i_in_item,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output lla_pkg::t_out_item                  o_out_item,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_we,
    input  logic [lla_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lla_pkg::MASK_W-1:0]          i_cfg_data
);

    // Flat cell address: row * GRID_COLS + col
    function automatic logic [lla_pkg::CELL_AW-1:0] cell_addr(
        logic [lla_pkg::ROW_W-1:0] row,
        logic [lla_pkg::COL_W-1:0] col
    );
        logic [31:0] full;
        full = 32'(row) * lla_pkg::GRID_COLS + 32'(col);
        return lla_pkg::CELL_AW'(full);
    endfunction

    // Level as reported on the 3-bit output field
    function automatic logic [2:0] to_out(lla_pkg::t_level v);
        logic [31:0] w;
        w = 32'(v);
        return w[2:0];
    endfunction

    // Generation rule for one cell
    function automatic lla_pkg::t_level next_level(
        lla_pkg::t_level                now,
        logic [lla_pkg::CNT_W-1:0]      n,
        logic [lla_pkg::MASK_W-1:0]     born,
        logic [lla_pkg::MASK_W-1:0]     surv
    );
        lla_pkg::t_level res;
        if (now == lla_pkg::LVL_ALIVE) begin
            res = surv[n] ? lla_pkg::LVL_ALIVE : lla_pkg::LVL_DECAY;
        end else if (born[n]) begin
            res = lla_pkg::LVL_ALIVE;
        end else if (now != '0) begin
            res = now - 1'b1;
        end else begin
            res = '0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    lla_pkg::t_state                  r_state, n_state;
    logic [lla_pkg::MASK_W-1:0]       r_born, r_surv;
    logic                             r_front;          // bank holding the current grid
    logic [lla_pkg::CELL_AW-1:0]      r_clr;            // clearing pass address
    logic [lla_pkg::ROW_W-1:0]        r_row;            // sweep row
    logic [lla_pkg::COL_W-1:0]        r_col;            // sweep column being fetched
    logic [1:0]                       r_phase;          // fetch phase within a column
    logic                             r_top_alive;      // fetched cell above
    lla_pkg::t_level                  r_mid_lvl;        // fetched cell on the row
    logic [2:0]                       r_prev;           // alive bits two columns back
    logic [2:0]                       r_cur;            // alive bits of the column being updated
    lla_pkg::t_level                  r_cur_lvl;        // level of the cell being updated
    logic                             r_rd_ok;          // read item lies inside the grid
    lla_pkg::t_out_item               r_res;            // result waiting for the output register
    logic                             r_out_valid;
    lla_pkg::t_out_item               r_out;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic                             in_inside;
    logic [lla_pkg::CELL_AW-1:0]      in_addr;
    lla_pkg::t_level                  in_clamped;
    lla_pkg::t_level                  rd0, rd1, rd_lvl;
    logic                             last_row, col_in, top_ok, bot_ok, bot_alive;
    logic [lla_pkg::ROW_W-1:0]        row_up, row_dn;
    logic [2:0]                       in_col;
    logic [7:0]                       nbrs;
    logic [lla_pkg::CNT_W-1:0]        n_cnt;
    lla_pkg::t_level                  new_lvl;
    logic                             out_load;

    // RAM port controls
    logic                             wr_en, wr_bank;
    logic [lla_pkg::CELL_AW-1:0]      wr_addr, rd_addr;
    lla_pkg::t_level                  wr_data;

    assign in_inside = (32'(i_in_item.row) < lla_pkg::GRID_ROWS) &&
                       (32'(i_in_item.col) < lla_pkg::GRID_COLS);
    assign in_addr   = in_inside ? cell_addr(lla_pkg::ROW_W'(i_in_item.row),
                                             lla_pkg::COL_W'(i_in_item.col)) : '0;
    // Clamp over-range writes to the alive level
    assign in_clamped = (32'(i_in_item.level_in) > lla_pkg::ALIVE_LEVEL) ?
                        lla_pkg::LVL_ALIVE : lla_pkg::LVL_W'(i_in_item.level_in);

    assign rd_lvl = r_front ? rd1 : rd0;

    // Neighbors beyond any edge read as dead
    assign last_row  = (32'(r_row) == lla_pkg::GRID_ROWS - 1);
    assign col_in    = (32'(r_col) < lla_pkg::GRID_COLS);
    assign top_ok    = (r_row != '0) && col_in;
    assign bot_ok    = !last_row && col_in;
    assign row_up    = r_row - 1'b1;
    assign row_dn    = r_row + 1'b1;
    assign bot_alive = bot_ok && (rd_lvl == lla_pkg::LVL_ALIVE);
    assign in_col    = {bot_alive, (r_mid_lvl == lla_pkg::LVL_ALIVE), r_top_alive};

    // Window: column k-2 in r_prev, k-1 in r_cur, incoming column k in in_col
    assign nbrs = {r_prev, r_cur[2], r_cur[0], in_col};

    always_comb begin
        n_cnt = '0;
        for (int i = 0; i < 8; i++) begin
            n_cnt = n_cnt + lla_pkg::CNT_W'(nbrs[i]);
        end
    end

    assign new_lvl  = next_level(r_cur_lvl, n_cnt, r_born, r_surv);
    assign out_load = (r_state == lla_pkg::S_FINISH) && (!r_out_valid || !i_out_stall);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lla_pkg::S_CLEAR: begin
                if (r_clr == lla_pkg::CELL_AW'(lla_pkg::CELLS - 1)) begin
                    n_state = lla_pkg::S_IDLE;
                end
            end
            lla_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_item.mode)
                        lla_pkg::MODE_WRITE: n_state = lla_pkg::S_FINISH;
                        lla_pkg::MODE_STEP:  n_state = lla_pkg::S_STEP;
                        lla_pkg::MODE_READ:  n_state = lla_pkg::S_RD_WAIT;
                        default:             n_state = lla_pkg::S_IDLE;
                    endcase
                end
            end
            lla_pkg::S_RD_WAIT: n_state = lla_pkg::S_FINISH;
            lla_pkg::S_STEP: begin
                if (r_phase == 2'd3 && !col_in && last_row) begin
                    n_state = lla_pkg::S_FINISH;
                end
            end
            lla_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = lla_pkg::S_IDLE;
                end
            end
            default: n_state = lla_pkg::S_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: handshake and RAM ports
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_bank    = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        unique case (r_state)
            lla_pkg::S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
            end
            lla_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                rd_addr    = in_addr;
                if (i_in_valid && i_in_item.mode == lla_pkg::MODE_WRITE && in_inside) begin
                    wr_en   = 1'b1;
                    wr_bank = r_front;
                    wr_addr = in_addr;
                    wr_data = in_clamped;
                end
            end
            lla_pkg::S_STEP: begin
                unique case (r_phase)
                    2'd0: rd_addr = top_ok ? cell_addr(row_up, r_col) : '0;
                    2'd1: rd_addr = col_in ? cell_addr(r_row, r_col) : '0;
                    2'd2: rd_addr = bot_ok ? cell_addr(row_dn, r_col) : '0;
                    2'd3: begin
                        // Retire the cell one column behind the fetch
                        if (r_col != '0) begin
                            wr_en   = 1'b1;
                            wr_bank = !r_front;
                            wr_addr = cell_addr(r_row, r_col - 1'b1);
                            wr_data = new_lvl;
                        end
                    end
                    default: rd_addr = '0;
                endcase
            end
            lla_pkg::S_RD_WAIT, lla_pkg::S_FINISH: begin
                o_in_stall = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lla_pkg::S_CLEAR;
            r_born      <= lla_pkg::MASK_W'(8);
            r_surv      <= lla_pkg::MASK_W'(12);
            r_front     <= 1'b0;
            r_clr       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Configuration is taken in any state
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lla_pkg::CFG_BORN:    r_born <= i_cfg_data;
                    lla_pkg::CFG_SURVIVE: r_surv <= i_cfg_data;
                endcase
            end

            unique case (r_state)
                lla_pkg::S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                lla_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_res.op_done <= i_in_item.mode;
                        r_rd_ok       <= in_inside;
                        if (i_in_item.mode == lla_pkg::MODE_WRITE) begin
                            r_res.level_out <= in_inside ? to_out(in_clamped) : 3'd0;
                        end else begin
                            r_res.level_out <= 3'd0;
                        end
                        // Arm the sweep at the top-left corner with a dead window
                        r_row     <= '0;
                        r_col     <= '0;
                        r_phase   <= '0;
                        r_prev    <= '0;
                        r_cur     <= '0;
                        r_cur_lvl <= '0;
                    end
                end
                lla_pkg::S_RD_WAIT: begin
                    r_res.level_out <= r_rd_ok ? to_out(rd_lvl) : 3'd0;
                end
                lla_pkg::S_STEP: begin
                    r_phase <= r_phase + 1'b1;
                    unique case (r_phase)
                        2'd0: begin
                        end
                        2'd1: r_top_alive <= top_ok && (rd_lvl == lla_pkg::LVL_ALIVE);
                        2'd2: r_mid_lvl   <= col_in ? rd_lvl : '0;
                        2'd3: begin
                            if (col_in) begin
                                // Shift the window one column right
                                r_prev    <= r_cur;
                                r_cur     <= in_col;
                                r_cur_lvl <= r_mid_lvl;
                                r_col     <= r_col + 1'b1;
                            end else begin
                                // Row done: restart at the left edge
                                r_prev    <= '0;
                                r_cur     <= '0;
                                r_cur_lvl <= '0;
                                r_col     <= '0;
                                r_row     <= r_row + 1'b1;
                                if (last_row) begin
                                    r_front <= !r_front;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                lla_pkg::S_FINISH: begin
                end
                default: begin
                end
            endcase

            // Output register: load a finished result, drop a taken one
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Grid banks: same addresses, write enable picks the bank
    // ------------------------------------------------------------------
    lla_ram #(
        .WIDTH(lla_pkg::LVL_W),
        .DEPTH(lla_pkg::CELLS)
    ) u_bank0 (
        .i_clk  (i_clk),
        .i_we   (wr_en && !wr_bank),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(rd0)
    );

    lla_ram #(
        .WIDTH(lla_pkg::LVL_W),
        .DEPTH(lla_pkg::CELLS)
    ) u_bank1 (
        .i_clk  (i_clk),
        .i_we   (wr_en && wr_bank),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(rd1)
    );

`ifndef SYNTHESIS
    // A sweep never writes the bank it is reading
    a_step_writes_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lla_pkg::S_STEP && wr_en) |-> (wr_bank != r_front))
        else $error("step wrote the front bank");

    // Items are taken only in idle
    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lla_pkg::S_IDLE) |-> o_in_stall)
        else $error("input not stalled while busy");

    // A new result appears only out of the finish state
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == lla_pkg::S_FINISH))
        else $error("result loaded outside finish");

    // Banks swap only at the end of a sweep
    a_swap_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front != $past(r_front)) |-> ($past(r_state) == lla_pkg::S_STEP))
        else $error("bank swap outside a step");
`endif

endmodule
